### design/avm_pkg.sv
package avm_pkg;

    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int LENGTH_BITS_DEF     = 24;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int PHASE_BITS    = 32;
    localparam int GAIN_BITS     = 16;
    localparam int ENV_BITS      = 16;
    // Envelope quotients never exceed 2^16, so 17 quotient bits suffice
    localparam int ENV_QUOT_BITS = ENV_BITS + 1;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    // pi/2 in Q30, seed of the sine table series
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_SELECT  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK_LEN   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_LEN    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SUSTAIN_GAIN = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NOTE_LEN     = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_LEN  = 3'd7;

    localparam logic WAVE_SAW = 1'b1;

endpackage

### design/avm_if.sv
interface avm_in_if #(
    parameter int SAMPLE_BITS = avm_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mix_in;
    logic                          restart;

    modport source (output valid, output mix_in, output restart, input ready);
    modport sink   (input valid, input mix_in, input restart, output ready);
endinterface

interface avm_out_if #(
    parameter int SAMPLE_BITS = avm_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mix_out;
    logic                          voice_active;
    logic                          voice_last;

    modport source (output valid, output mix_out, output voice_active, output voice_last,
                    input ready);
    modport sink   (input valid, input mix_out, input voice_active, input voice_last,
                    output ready);
endinterface

### design/avm_sine_rom.sv
module avm_sine_rom #(
    parameter int SAMPLE_BITS     = avm_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = avm_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [SINE_TABLE_BITS:0]   addr,
    output logic [SAMPLE_BITS-2:0]     data
);
    import avm_pkg::*;

    localparam int TAB_N = 1 << SINE_TABLE_BITS;

    typedef logic [SAMPLE_BITS-2:0] sine_tab_t [0:TAB_N];

    // Quarter-wave table from an integer Taylor series in Q30, terms up to x^13
    function automatic sine_tab_t build_tab();
        sine_tab_t       tab;
        longint unsigned amp;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned s;
        longint unsigned v;
        amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
        for (int k = 0; k <= TAB_N; k++)
        begin
            x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            pos  = 64'd0;
            neg  = 64'd0;
            for (int n = 1; n <= 13; n += 2)
            begin
                if ((((n - 1) / 2) % 2) == 1)
                begin
                    neg = neg + term;
                end
                else
                begin
                    pos = pos + term;
                end
                term = ((term * x2) >> 30) / 64'((n + 1) * (n + 2));
            end
            s = (pos > neg) ? pos - neg : 64'd0;
            v = (s * amp + (64'd1 << 29)) >> 30;
            if (v > amp)
            begin
                v = amp;
            end
            tab[k] = v[SAMPLE_BITS-2:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_tab();

    logic [SAMPLE_BITS-2:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_reg <= SINE_TAB[addr];
        end
    end

    assign data = data_reg;

endmodule

### design/avm_divider.sv
module avm_divider #(
    parameter int LENGTH_BITS = avm_pkg::LENGTH_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic [LENGTH_BITS+avm_pkg::ENV_QUOT_BITS-1:0] num,
    input  logic [LENGTH_BITS-1:0]                        den,
    output logic                                          done,
    output logic [avm_pkg::ENV_QUOT_BITS-1:0]             quot
);
    import avm_pkg::*;

    localparam int QB    = ENV_QUOT_BITS;
    localparam int CNT_W = $clog2(QB + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [LENGTH_BITS-1:0] den_reg, den_next;
    logic [QB-1:0]    low_reg, low_next;
    logic [QB-1:0]    quot_reg, quot_next;

    logic [LENGTH_BITS:0]   trial;
    logic [LENGTH_BITS+1:0] diff;
    logic                   ge;

    // Restoring step: the quotient is known to fit QB bits, so the top
    // numerator bits already lie below the divisor
    assign trial = {rem_reg, low_reg[QB-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign ge    = ~diff[LENGTH_BITS+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QB);
            rem_next  = num[LENGTH_BITS+QB-1:QB];
            low_next  = num[QB-1:0];
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[LENGTH_BITS-1:0] : trial[LENGTH_BITS-1:0];
            low_next  = {low_reg[QB-2:0], 1'b0};
            quot_next = {quot_reg[QB-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### design/adsr_oscillator_voice_mixer_core.sv
// Sequence: S_ENV, S_OUT for an idle voice; S_ENV, S_NUM, S_LVL, S_OUT in sustain or at
// zero level; S_ENV, S_NUM, S_DIV, S_WAIT, S_LVL, S_OUT during attack, decay or release,
// where S_WAIT waits on the 17-step shared divider. The input reopens once the word
// enters the output register, so a word is taken only after the last one is through.
// A full output register stalls the sequencer until the sink takes its word.
// Reset: asynchronous, active low; configuration registers clear to 0, the sample count
// to all ones (idle), the phase to 0. The sine table is a constant ROM and needs no fill.
module adsr_oscillator_voice_mixer_core #(
    parameter int SAMPLE_BITS     = avm_pkg::SAMPLE_BITS_DEF,
    parameter int LENGTH_BITS     = avm_pkg::LENGTH_BITS_DEF,
    parameter int SINE_TABLE_BITS = avm_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [avm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [avm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    avm_in_if.sink                             sample_in,
    avm_out_if.source                          sample_out
);
    import avm_pkg::*;

    localparam int CW  = LENGTH_BITS + 2;              // sample count width
    localparam int MA  = SAMPLE_BITS + GAIN_BITS;      // shared multiplier, operand a
    localparam int MB  = (LENGTH_BITS > ENV_BITS) ? LENGTH_BITS : ENV_BITS;
    localparam int NUM_W = LENGTH_BITS + ENV_QUOT_BITS;
    localparam int SB  = SAMPLE_BITS;

    localparam logic [ENV_QUOT_BITS-1:0] ENV_ONE = ENV_QUOT_BITS'(1) << ENV_BITS;
    localparam logic signed [SB+1:0] SUM_MAX = (SB + 2)'((1 << (SB - 1)) - 1);
    localparam logic signed [SB+1:0] SUM_MIN = ~SUM_MAX;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ENV  = 7'b0000010,
        S_NUM  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_WAIT = 7'b0010000,
        S_LVL  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        ENV_ATK  = 3'd0,
        ENV_DEC  = 3'd1,
        ENV_SUS  = 3'd2,
        ENV_REL  = 3'd3,
        ENV_ZERO = 3'd4
    } env_mode_t;

    // ---------------------------------------------------------------------
    // Configuration registers; the block leaves it to the user to write them only while the voice is idle
    // ---------------------------------------------------------------------
    logic [PHASE_BITS-1:0]  phase_step_reg;
    logic                   wave_select_reg;
    logic [GAIN_BITS-1:0]   gain_reg;
    logic [LENGTH_BITS-1:0] attack_len_reg;
    logic [LENGTH_BITS-1:0] decay_len_reg;
    logic [ENV_BITS-1:0]    sustain_gain_reg;
    logic [LENGTH_BITS-1:0] note_len_reg;
    logic [LENGTH_BITS-1:0] release_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= '0;
            wave_select_reg  <= 1'b0;
            gain_reg         <= '0;
            attack_len_reg   <= '0;
            decay_len_reg    <= '0;
            sustain_gain_reg <= '0;
            note_len_reg     <= '0;
            release_len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PHASE_STEP:   phase_step_reg   <= cfg_data[PHASE_BITS-1:0];
                REG_WAVE_SELECT:  wave_select_reg  <= cfg_data[0];
                REG_GAIN:         gain_reg         <= cfg_data[GAIN_BITS-1:0];
                REG_ATTACK_LEN:   attack_len_reg   <= cfg_data[LENGTH_BITS-1:0];
                REG_DECAY_LEN:    decay_len_reg    <= cfg_data[LENGTH_BITS-1:0];
                REG_SUSTAIN_GAIN: sustain_gain_reg <= cfg_data[ENV_BITS-1:0];
                REG_NOTE_LEN:     note_len_reg     <= cfg_data[LENGTH_BITS-1:0];
                REG_RELEASE_LEN:  release_len_reg  <= cfg_data[LENGTH_BITS-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer state and voice state
    // ---------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [CW-1:0]         count_reg, count_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;

    logic                  accept;
    logic [CW-1:0]         count_cur;
    logic [PHASE_BITS-1:0] phase_cur;

    // Per-word working registers (payload, no reset)
    logic signed [SB-1:0]   mix_reg;
    logic [CW-1:0]          c_reg;
    logic [PHASE_BITS-1:0]  ph_reg;
    env_mode_t              mode_reg, mode_next;
    logic [ENV_QUOT_BITS-1:0] x_reg, x_next;
    logic [LENGTH_BITS-1:0] y_reg, y_next;
    logic [LENGTH_BITS-1:0] den_reg, den_next;
    logic                   active_reg, active_next;
    logic                   last_reg, last_next;
    logic                   neg_reg, neg_next;
    logic [MA-1:0]          mg_reg;
    logic [ENV_BITS-1:0]    env_reg, env_next;
    logic [MA+MB-1:0]       mul_reg;

    // Output register parting the sequencer from the sink
    logic                   out_valid_reg;
    logic signed [SB-1:0]   out_mix_reg;
    logic                   out_active_reg;
    logic                   out_last_reg;
    logic                   load_out;

    assign sample_in.ready = (state_reg == S_IDLE);
    assign accept          = sample_in.valid & sample_in.ready;

    // A restart zeroes count and phase for this word itself
    assign count_cur = sample_in.restart ? '0 : count_reg;
    assign phase_cur = sample_in.restart ? '0 : phase_reg;

    always_comb
    begin
        count_next = count_reg;
        phase_next = phase_reg;
        if (accept)
        begin
            // Saturate the count at all ones, which lies past any note end
            count_next = (&count_cur) ? count_cur : count_cur + CW'(1);
            phase_next = phase_cur + phase_step_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Sine ROM: address the quadrant-folded index at accept, data next cycle
    // ---------------------------------------------------------------------
    logic [SINE_TABLE_BITS-1:0] rom_idx;
    logic [SINE_TABLE_BITS:0]   rom_addr;
    logic [SB-2:0]              rom_data;

    assign rom_idx  = phase_cur[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign rom_addr = phase_cur[PHASE_BITS-2]
                    ? {1'b1, {SINE_TABLE_BITS{1'b0}}} - {1'b0, rom_idx}
                    : {1'b0, rom_idx};

    avm_sine_rom #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk   (clk),
        .rd_en (accept),
        .addr  (rom_addr),
        .data  (rom_data)
    );

    // ---------------------------------------------------------------------
    // Oscillator magnitude and sign
    // ---------------------------------------------------------------------
    logic signed [SB-1:0] saw_val;
    logic [SB-1:0]        osc_mag;
    logic                 osc_neg;

    assign saw_val = ph_reg[PHASE_BITS-1 -: SB];

    always_comb
    begin
        if (wave_select_reg == WAVE_SAW)
        begin
            osc_neg = ph_reg[PHASE_BITS-1];
            osc_mag = osc_neg ? SB'(-saw_val) : SB'(saw_val);
        end
        else
        begin
            // Negative half of the sine: upper quadrant bit set
            osc_neg = ph_reg[PHASE_BITS-1];
            osc_mag = {1'b0, rom_data};
        end
    end

    // ---------------------------------------------------------------------
    // Envelope segment decode, from the count of this word
    // ---------------------------------------------------------------------
    logic [LENGTH_BITS:0] ad_sum;
    logic [LENGTH_BITS:0] end_sum;
    logic [CW-1:0]        c_minus_a;
    logic [CW-1:0]        c_minus_n;

    assign ad_sum    = {1'b0, attack_len_reg} + {1'b0, decay_len_reg};
    assign end_sum   = {1'b0, note_len_reg} + {1'b0, release_len_reg};
    assign c_minus_a = c_reg - CW'(attack_len_reg);
    assign c_minus_n = c_reg - CW'(note_len_reg);

    always_comb
    begin
        active_next = (c_reg <= CW'(end_sum));
        last_next   = (c_reg == CW'(end_sum));
        neg_next    = osc_neg;
        mode_next   = ENV_ZERO;
        x_next      = '0;
        y_next      = '0;
        den_next    = '0;
        priority if (c_reg < CW'(attack_len_reg))
        begin
            // Attack: c * 2^16 / A
            mode_next = ENV_ATK;
            x_next    = ENV_ONE;
            y_next    = c_reg[LENGTH_BITS-1:0];
            den_next  = attack_len_reg;
        end
        else if (c_reg < CW'(ad_sum))
        begin
            // Decay: S + (2^16 - S) * (D - (c - A)) / D
            mode_next = ENV_DEC;
            x_next    = ENV_ONE - {1'b0, sustain_gain_reg};
            y_next    = decay_len_reg - c_minus_a[LENGTH_BITS-1:0];
            den_next  = decay_len_reg;
        end
        else if (c_reg < CW'(note_len_reg))
        begin
            mode_next = ENV_SUS;
        end
        else if (release_len_reg == '0)
        begin
            mode_next = ENV_ZERO;
        end
        else
        begin
            // Release: S * (R - (c - N)) / R; only carried out while active
            mode_next = ENV_REL;
            x_next    = {1'b0, sustain_gain_reg};
            y_next    = release_len_reg - c_minus_n[LENGTH_BITS-1:0];
            den_next  = release_len_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Shared multiplier: mag*gain, then the envelope numerator, then the level
    // ---------------------------------------------------------------------
    logic [MA-1:0] mul_a;
    logic [MB-1:0] mul_b;
    logic          mul_en;

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        unique case (state_reg)
            S_ENV:
            begin
                mul_a  = MA'(osc_mag);
                mul_b  = MB'(gain_reg);
                mul_en = 1'b1;
            end
            S_NUM:
            begin
                mul_a  = MA'(x_reg);
                mul_b  = MB'(y_reg);
                mul_en = 1'b1;
            end
            S_LVL:
            begin
                mul_a  = mg_reg;
                mul_b  = MB'(env_reg);
                mul_en = 1'b1;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Shared divider for the envelope ramps
    // ---------------------------------------------------------------------
    logic                     div_start;
    logic                     div_done;
    logic [ENV_QUOT_BITS-1:0] div_quot;
    logic [ENV_QUOT_BITS-1:0] dec_sum;

    assign div_start = (state_reg == S_DIV);
    assign dec_sum   = ENV_QUOT_BITS'(sustain_gain_reg) + div_quot;

    avm_divider #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_reg[NUM_W-1:0]),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        env_next   = env_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_ENV;
                end
            end
            S_ENV:
            begin
                // Skip the voice entirely when past the end of its release
                state_next = active_next ? S_NUM : S_OUT;
            end
            S_NUM:
            begin
                if (mode_reg == ENV_SUS)
                begin
                    env_next   = sustain_gain_reg;
                    state_next = S_LVL;
                end
                else if (mode_reg == ENV_ZERO)
                begin
                    env_next   = '0;
                    state_next = S_LVL;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    if (mode_reg == ENV_DEC)
                    begin
                        // Cap the decay peak of 2^16
                        env_next = dec_sum[ENV_BITS] ? '1 : dec_sum[ENV_BITS-1:0];
                    end
                    else
                    begin
                        env_next = div_quot[ENV_BITS-1:0];
                    end
                    state_next = S_LVL;
                end
            end
            S_LVL:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '1;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mix_reg <= sample_in.mix_in;
            c_reg   <= count_cur;
            ph_reg  <= phase_cur;
        end
        if (state_reg == S_ENV)
        begin
            mode_reg   <= mode_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            den_reg    <= den_next;
            active_reg <= active_next;
            last_reg   <= last_next;
            neg_reg    <= neg_next;
        end
        if (state_reg == S_NUM)
        begin
            mg_reg <= mul_reg[MA-1:0];
        end
        if (mul_en)
        begin
            mul_reg <= mul_a * mul_b;
        end
        env_reg <= env_next;
    end

    // ---------------------------------------------------------------------
    // Voice sum and saturation
    // ---------------------------------------------------------------------
    logic [SB-1:0]          voice_mag;
    logic signed [SB+1:0]   mix_wide;
    logic signed [SB+1:0]   voice_wide;
    logic signed [SB+1:0]   sum_wide;
    logic signed [SB-1:0]   sum_sat;
    logic signed [SB-1:0]   result_mix;

    // Drop the low 31 bits of osc * gain * env
    assign voice_mag  = mul_reg[SB+30:31];
    assign mix_wide   = {{2{mix_reg[SB-1]}}, mix_reg};
    assign voice_wide = {2'b00, voice_mag};
    assign sum_wide   = neg_reg ? mix_wide - voice_wide : mix_wide + voice_wide;

    always_comb
    begin
        priority if (sum_wide > SUM_MAX)
        begin
            sum_sat = SUM_MAX[SB-1:0];
        end
        else if (sum_wide < SUM_MIN)
        begin
            sum_sat = SUM_MIN[SB-1:0];
        end
        else
        begin
            sum_sat = sum_wide[SB-1:0];
        end
    end

    assign result_mix = active_reg ? sum_sat : mix_reg;

    // Hold the finished word until the sink takes it
    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || sample_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (sample_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_mix_reg    <= result_mix;
            out_active_reg <= active_reg;
            out_last_reg   <= active_reg & last_reg;
        end
    end

    assign sample_out.valid        = out_valid_reg;
    assign sample_out.mix_out      = out_mix_reg;
    assign sample_out.voice_active = out_active_reg;
    assign sample_out.voice_last   = out_last_reg;

endmodule
